// ===== rtl/ssf_pkg.sv =====
// ----------------------------------------------------------------------------
// ssf_pkg
// Shared types and constants of the scanline span filler.
// ----------------------------------------------------------------------------
`default_nettype none

package ssf_pkg;

    localparam int CROSS_X_W  = 22;
    localparam int EDGE_DIR_W = 2;
    localparam int SPAN_W     = 14;
    localparam int WORD_IDX_W = 8;
    localparam int MASK_W     = 32;
    localparam int BYTE_W     = 8;
    localparam int WIND_W     = 8;

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 152;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;

    localparam logic [CFG_INDEX_W-1:0] CFG_FILL_RULE    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_INVERT       = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_BINARY_BLACK = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_GRAY_VALUE   = 2'd3;

    localparam logic RULE_ODD_EVEN = 1'b0;
    localparam logic RULE_WINDING  = 1'b1;

    localparam logic [MASK_W-1:0] FULL_MASK = '1;

    typedef struct packed {
        logic              fill_rule;
        logic              invert;
        logic              binary_black;
        logic [BYTE_W-1:0] gray_value;
    } t_cfg;

    typedef struct packed {
        logic [BYTE_W-1:0]     fill_byte;
        logic [MASK_W-1:0]     pattern_word;
        logic [MASK_W-1:0]     tail_mask;
        logic [MASK_W-1:0]     head_mask;
        logic [WORD_IDX_W-1:0] tail_word;
        logic [WORD_IDX_W-1:0] head_word;
        logic [SPAN_W-1:0]     span_stop;
        logic [SPAN_W-1:0]     span_start;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/ssf_front.sv =====
// ----------------------------------------------------------------------------
// ssf_front
// Rounds each crossing to a column, tracks parity and winding sum, and
// pushes every non-empty filled span into the span queue.
// ----------------------------------------------------------------------------
`default_nettype none

module ssf_front
    import ssf_pkg::*;
#(
    parameter int LINE_WIDTH = 8192,
    parameter int FRAC_BITS  = 8,
    parameter int COL_W      = 14
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_cfg                  i_cfg,
    input  wire logic                  i_valid,
    input  wire logic                  i_ready,
    input  wire logic [CROSS_X_W-1:0]  i_cross_x,
    input  wire logic [EDGE_DIR_W-1:0] i_edge_dir,
    input  wire logic                  i_line_end,
    output logic                       o_push,
    output logic [COL_W-1:0]           o_start,
    output logic [COL_W-1:0]           o_stop
);

    localparam int HALF = (1 << FRAC_BITS) >> 1;
    localparam int SUM_W = CROSS_X_W + 1;

    logic [WIND_W-1:0] r_wind, n_wind;
    logic [COL_W-1:0]  r_prev, n_prev;
    logic              r_parity, n_parity;
    logic              r_have, n_have;

    logic [SUM_W-1:0]  w_sum;
    logic [SUM_W-1:0]  w_shift;
    logic [COL_W-1:0]  w_col;
    logic [WIND_W-1:0] w_dir;
    logic              w_fill;
    logic              w_accept;

    assign w_accept = i_valid && i_ready;
    assign w_sum    = {1'b0, i_cross_x} + SUM_W'(HALF);
    assign w_shift  = w_sum >> FRAC_BITS;
    assign w_col    = (w_shift > SUM_W'(LINE_WIDTH)) ? COL_W'(LINE_WIDTH)
                                                     : w_shift[COL_W-1:0];
    assign w_dir    = {{(WIND_W-EDGE_DIR_W){i_edge_dir[EDGE_DIR_W-1]}}, i_edge_dir};

    always_comb begin
        if (!r_have) begin
            w_fill = 1'b0;
        end else if (i_cfg.fill_rule == RULE_ODD_EVEN) begin
            w_fill = r_parity;
        end else begin
            w_fill = ((r_wind == '0) == i_cfg.invert);
        end
    end

    assign o_push  = w_accept && w_fill && (w_col > r_prev);
    assign o_start = r_prev;
    assign o_stop  = w_col;

    always_comb begin
        n_wind   = r_wind;
        n_prev   = r_prev;
        n_parity = r_parity;
        n_have   = r_have;
        if (w_accept) begin
            if (i_line_end) begin
                n_wind   = '0;
                n_prev   = '0;
                n_parity = 1'b0;
                n_have   = 1'b0;
            end else begin
                n_wind   = r_wind + w_dir;
                n_prev   = w_col;
                n_parity = !r_parity;
                n_have   = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wind   <= '0;
            r_prev   <= '0;
            r_parity <= 1'b0;
            r_have   <= 1'b0;
        end else begin
            r_wind   <= n_wind;
            r_prev   <= n_prev;
            r_parity <= n_parity;
            r_have   <= n_have;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ssf_queue.sv =====
// ----------------------------------------------------------------------------
// ssf_queue
// Two-entry span queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module ssf_queue #(
    parameter int DATA_W = 28
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire logic [DATA_W-1:0] i_data,
    input  wire logic              i_pop,
    output logic                   o_ready,
    output logic                   o_valid,
    output logic [DATA_W-1:0]      o_data
);

    logic [DATA_W-1:0] r_mem [2];
    logic              r_wr_ptr, n_wr_ptr;
    logic              r_rd_ptr, n_rd_ptr;
    logic [1:0]        r_count, n_count;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = !r_wr_ptr;
        end
        if (i_pop) begin
            n_rd_ptr = !r_rd_ptr;
        end
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 2'd1;
            2'b01:   n_count = r_count - 2'd1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ssf_back.sv =====
// ----------------------------------------------------------------------------
// ssf_back
// Turns a queued span into word indices and edge masks and holds the
// result in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ssf_back
    import ssf_pkg::*;
#(
    parameter int COL_W = 14
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_cfg             i_cfg,
    input  wire logic             i_q_valid,
    input  wire logic [COL_W-1:0] i_start,
    input  wire logic [COL_W-1:0] i_stop,
    output logic                  o_pop,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output t_result               o_result
);

    logic    r_valid, n_valid;
    t_result r_result;
    t_result w_result;

    logic [COL_W-1:0]  w_last;
    logic [31:0]       w_start32;
    logic [31:0]       w_stop32;
    logic [31:0]       w_last32;
    logic [MASK_W-1:0] w_hmask;
    logic [MASK_W-1:0] w_tmask;
    logic              w_same;

    assign w_last    = i_stop - COL_W'(1);
    assign w_start32 = 32'(i_start);
    assign w_stop32  = 32'(i_stop);
    assign w_last32  = 32'(w_last);
    assign w_hmask   = FULL_MASK >> i_start[4:0];
    assign w_tmask   = FULL_MASK << (~w_last[4:0]);
    assign w_same    = (i_start[COL_W-1:5] == w_last[COL_W-1:5]);

    always_comb begin
        w_result.span_start   = w_start32[SPAN_W-1:0];
        w_result.span_stop    = w_stop32[SPAN_W-1:0];
        w_result.head_word    = w_start32[WORD_IDX_W+4:5];
        w_result.tail_word    = w_last32[WORD_IDX_W+4:5];
        w_result.head_mask    = w_same ? (w_hmask & w_tmask) : w_hmask;
        w_result.tail_mask    = w_same ? (w_hmask & w_tmask) : w_tmask;
        w_result.pattern_word = i_cfg.binary_black ? FULL_MASK : '0;
        w_result.fill_byte    = i_cfg.gray_value;
    end

    assign o_pop    = i_q_valid && (!r_valid || i_ready);
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_comb begin
        n_valid = r_valid;
        if (o_pop) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_result <= w_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/scanline_span_filler.sv =====
// ----------------------------------------------------------------------------
// scanline_span_filler
// Span generator for scanline polygon fill.
// ----------------------------------------------------------------------------
// Accepts one sorted edge crossing per cycle and returns at most one span per
// crossing, one per cycle when the output is free, by way of the queue and the
// back's output register. The front rounds and classifies a crossing in the cycle
// it is taken; a two-entry span queue decouples it from the back, whose
// output register holds the result while the next crossings keep flowing.
// The input stalls only when the queue is full behind a stalled output.
// ----------------------------------------------------------------------------
`default_nettype none

module scanline_span_filler
    import ssf_pkg::*;
#(
    parameter int LINE_WIDTH = 8192,
    parameter int FRAC_BITS  = 8
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                   i_s_tvalid,
    output logic                        o_s_tready,
    // cross_x[21:0], edge_dir[23:22]
    input  wire logic [IN_TDATA_W-1:0]  i_s_tdata,
    // line_end
    input  wire logic                   i_s_tlast,
    output logic                        o_m_tvalid,
    input  wire logic                   i_m_tready,
    // span_start[13:0], span_stop[27:14], head_word[35:28], tail_word[43:36],
    // head_mask[75:44], tail_mask[107:76], pattern_word[139:108],
    // fill_byte[147:140], zero[151:148]
    output logic [OUT_TDATA_W-1:0]      o_m_tdata
);

    localparam int COL_W = $clog2(LINE_WIDTH + 1);

    t_cfg             r_cfg;
    logic             w_push;
    logic [COL_W-1:0] w_start;
    logic [COL_W-1:0] w_stop;
    logic             w_q_ready;
    logic             w_q_valid;
    logic [2*COL_W-1:0] w_q_data;
    logic             w_pop;
    t_result          w_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fill_rule    <= 1'b0;
            r_cfg.invert       <= 1'b0;
            r_cfg.binary_black <= 1'b1;
            r_cfg.gray_value   <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_FILL_RULE:    r_cfg.fill_rule    <= i_cfg_data[0];
                CFG_INVERT:       r_cfg.invert       <= i_cfg_data[0];
                CFG_BINARY_BLACK: r_cfg.binary_black <= i_cfg_data[0];
                CFG_GRAY_VALUE:   r_cfg.gray_value   <= i_cfg_data;
                default:          r_cfg              <= r_cfg;
            endcase
        end
    end

    assign o_s_tready = w_q_ready;

    ssf_front #(
        .LINE_WIDTH (LINE_WIDTH),
        .FRAC_BITS  (FRAC_BITS),
        .COL_W      (COL_W)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_valid    (i_s_tvalid),
        .i_ready    (w_q_ready),
        .i_cross_x  (i_s_tdata[CROSS_X_W-1:0]),
        .i_edge_dir (i_s_tdata[CROSS_X_W+EDGE_DIR_W-1:CROSS_X_W]),
        .i_line_end (i_s_tlast),
        .o_push     (w_push),
        .o_start    (w_start),
        .o_stop     (w_stop)
    );

    ssf_queue #(
        .DATA_W  (2*COL_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  ({w_stop, w_start}),
        .i_pop   (w_pop),
        .o_ready (w_q_ready),
        .o_valid (w_q_valid),
        .o_data  (w_q_data)
    );

    ssf_back #(
        .COL_W     (COL_W)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (w_q_valid),
        .i_start   (w_q_data[COL_W-1:0]),
        .i_stop    (w_q_data[2*COL_W-1:COL_W]),
        .o_pop     (w_pop),
        .o_valid   (o_m_tvalid),
        .i_ready   (i_m_tready),
        .o_result  (w_result)
    );

    assign o_m_tdata = {{(OUT_TDATA_W-$bits(t_result)){1'b0}}, w_result};

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && i_m_tready && !w_q_valid |=> !o_m_tvalid)
        else $error("output held with nothing queued");

    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_valid && !o_m_tvalid |=> o_m_tvalid)
        else $error("queued span did not reach the output");

    a_masks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (w_result.head_mask != '0) && (w_result.tail_mask != '0))
        else $error("empty edge mask on a span");

endmodule

`default_nettype wire
